>>> hdl/slmc_pkg.sv
// Package for the slew-limited motor command unit.
// Holds field widths, register indexes, reset values, frame codes and the config struct.
// No dependencies; every other file of the block imports it.
package slmc_pkg;

    localparam int SPEED_WIDTH_DEF = 32;
    localparam int STEP_W          = 20;
    localparam int ID_W            = 29;
    localparam int TARGET_W        = 32;
    localparam int WIRE_SPEED_W    = 32;
    localparam int BYTE_W          = 8;
    localparam int LANES           = 3;
    localparam int QUEUE_DEPTH     = 2;

    // input word: cmd_valid, cmd_stop, safety_stop, then three targets
    localparam int IN_FLAG_W   = 3;
    localparam int IN_RAW_W    = IN_FLAG_W + LANES * TARGET_W;
    localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int IN_CMD_VALID_BIT = 0;
    localparam int IN_CMD_STOP_BIT  = 1;
    localparam int IN_SAFETY_BIT    = 2;
    localparam int IN_TARGET_LSB    = IN_FLAG_W;

    // output word: frame_id, data_byte0..3
    localparam int OUT_RAW_W   = ID_W + 4 * BYTE_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_ID  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ID = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_EXCAV_ID = CFG_IDX_W'(3);

    localparam logic [STEP_W-1:0] MAX_STEP_RST = STEP_W'(1000);

    localparam logic [1:0] FRAME_LEFT  = 2'd0;
    localparam logic [1:0] FRAME_RIGHT = 2'd1;
    localparam logic [1:0] FRAME_EXCAV = 2'd2;

    typedef struct packed {
        logic [STEP_W-1:0] max_step;
        logic [ID_W-1:0]   left_id;
        logic [ID_W-1:0]   right_id;
        logic [ID_W-1:0]   excav_id;
    } t_cfg;

endpackage

>>> hdl/slew_limited_motor_command_unit.sv
// Slew-limited motor command unit: one input word is one control tick; each tick gives three
// output words (left drive, right drive, excavation belt), the last with tlast set. The front
// end takes one tick per cycle into a two-entry queue while the queue is not full; the back
// end sends one word per cycle over the single output channel while tready is high. When the
// back end is idle, a tick's first word goes through the queue, then the output register.
// Configuration writes are taken in every cycle and belong to idle periods only.
module slew_limited_motor_command_unit #(
    parameter int SPEED_WIDTH = slmc_pkg::SPEED_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cmd_valid, cmd_stop, safety_stop, left_target, right_target, excav_target, zero fill
    input  logic [slmc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // target_valid
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // frame_id, data_byte0, data_byte1, data_byte2, data_byte3, zero fill
    output logic [slmc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // last_frame
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [slmc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [slmc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import slmc_pkg::*;

    localparam int EW = LANES * SPEED_WIDTH;

    t_cfg          r_cfg;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    logic [EW-1:0] push_data;
    logic [EW-1:0] head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_step <= MAX_STEP_RST;
            r_cfg.left_id  <= '0;
            r_cfg.right_id <= '0;
            r_cfg.excav_id <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MAX_STEP: r_cfg.max_step <= i_cfg_data[STEP_W-1:0];
                REG_LEFT_ID:  r_cfg.left_id  <= i_cfg_data[ID_W-1:0];
                REG_RIGHT_ID: r_cfg.right_id <= i_cfg_data[ID_W-1:0];
                REG_EXCAV_ID: r_cfg.excav_id <= i_cfg_data[ID_W-1:0];
                default: ;
            endcase
        end
    end

    slmc_front #(.SW(SPEED_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .i_max_step (r_cfg.max_step),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (push_data)
    );

    slmc_queue #(.W(EW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    slmc_back #(.SW(SPEED_WIDTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (head),
        .i_empty  (empty),
        .o_pop    (pop),
        .i_cfg    (r_cfg),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

>>> hdl/slmc_front.sv
// Front end: accepts control ticks, applies run/stop and safety stop, steps the speeds.
// Keeps the stop flag, goals and speeds; pushes the new speeds of each tick to the queue.
// Depends on slmc_pkg.
module slmc_front #(
    parameter int SW = slmc_pkg::SPEED_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [slmc_pkg::IN_TDATA_W-1:0]  i_tdata,
    input  logic                             i_tuser,
    input  logic [slmc_pkg::STEP_W-1:0]      i_max_step,
    input  logic                             i_full,
    output logic                             o_push,
    output logic [slmc_pkg::LANES*SW-1:0]    o_entry
);
    import slmc_pkg::*;

    localparam int DW = (SW + 2 > STEP_W + 2) ? SW + 2 : STEP_W + 2;
    localparam logic signed [TARGET_W-1:0] SPD_MAX =
        TARGET_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [TARGET_W-1:0] SPD_MIN = -SPD_MAX - TARGET_W'(1);

    logic                 r_stop;
    logic signed [SW-1:0] r_speed [LANES];
    logic signed [SW-1:0] r_goal  [LANES];

    logic                 n_stop;
    logic signed [SW-1:0] n_speed [LANES];
    logic signed [SW-1:0] n_goal  [LANES];
    logic                 accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        logic signed [TARGET_W-1:0] tgt;
        logic signed [SW-1:0]       tgt_sat;
        logic signed [SW-1:0]       goal_use;
        logic signed [DW-1:0]       diff;
        logic signed [DW-1:0]       lim;
        logic signed [DW-1:0]       up;
        logic signed [DW-1:0]       dn;
        n_stop = i_tdata[IN_CMD_VALID_BIT] ? i_tdata[IN_CMD_STOP_BIT] : r_stop;
        if (i_tdata[IN_SAFETY_BIT]) begin
            n_stop = 1'b1;
        end
        lim = DW'($unsigned(i_max_step));
        for (int k = 0; k < LANES; k++) begin
            tgt = $signed(i_tdata[IN_TARGET_LSB + k*TARGET_W +: TARGET_W]);
            if (tgt > SPD_MAX) begin
                tgt_sat = SW'(SPD_MAX);
            end else if (tgt < SPD_MIN) begin
                tgt_sat = SW'(SPD_MIN);
            end else begin
                tgt_sat = SW'(tgt);
            end
            goal_use = (!n_stop && i_tuser) ? tgt_sat : r_goal[k];
            n_goal[k] = goal_use;
            diff = DW'(goal_use) - DW'(r_speed[k]);
            up   = DW'(r_speed[k]) + lim;
            dn   = DW'(r_speed[k]) - lim;
            // zero on stop; otherwise clamp the move to max_step; never overshoot the goal
            if (n_stop) begin
                n_speed[k] = '0;
            end else if (diff > lim) begin
                n_speed[k] = SW'(up);
            end else if (diff < -lim) begin
                n_speed[k] = SW'(dn);
            end else begin
                n_speed[k] = goal_use;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop <= 1'b1;
            for (int k = 0; k < LANES; k++) begin
                r_speed[k] <= '0;
                r_goal[k]  <= '0;
            end
        end else if (accept) begin
            r_stop <= n_stop;
            for (int k = 0; k < LANES; k++) begin
                r_speed[k] <= n_speed[k];
                r_goal[k]  <= n_goal[k];
            end
        end
    end

    assign o_push = accept;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            o_entry[k*SW +: SW] = n_speed[k];
        end
    end

endmodule

>>> hdl/slmc_queue.sv
// Short queue between front and back end; one entry holds the three speeds of a tick.
// Two entries, register storage, one write and one read port.
// Depends on slmc_pkg.
module slmc_queue #(
    parameter int W = slmc_pkg::LANES * slmc_pkg::SPEED_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    import slmc_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

>>> hdl/slmc_back.sv
// Back end: turns each queued tick into three frames, left, right, excavation.
// Output register on the master side; pops the queue when the third frame loads.
// Depends on slmc_pkg.
module slmc_back #(
    parameter int SW = slmc_pkg::SPEED_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [slmc_pkg::LANES*SW-1:0]     i_entry,
    input  logic                              i_empty,
    output logic                              o_pop,
    input  slmc_pkg::t_cfg                    i_cfg,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [slmc_pkg::OUT_TDATA_W-1:0]  o_tdata,
    output logic                              o_tlast
);
    import slmc_pkg::*;

    logic [1:0]             r_sel;
    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_tdata;
    logic                   r_tlast;

    logic                   load;
    logic                   is_last;
    logic [ID_W-1:0]        id;
    logic signed [SW-1:0]   spd;
    logic [WIRE_SPEED_W-1:0] spd32;

    assign load    = !i_empty && (!r_valid || i_tready);
    assign is_last = (r_sel == FRAME_EXCAV);
    assign o_pop   = load && is_last;

    always_comb begin
        unique case (r_sel)
            FRAME_LEFT: begin
                id  = i_cfg.left_id;
                spd = $signed(i_entry[0 +: SW]);
            end
            FRAME_RIGHT: begin
                id  = i_cfg.right_id;
                spd = $signed(i_entry[SW +: SW]);
            end
            FRAME_EXCAV: begin
                id  = i_cfg.excav_id;
                spd = $signed(i_entry[2*SW +: SW]);
            end
            default: begin
                id  = '0;
                spd = '0;
            end
        endcase
        spd32 = WIRE_SPEED_W'(spd);
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            // big-endian: byte0 carries speed bits 31..24
            r_tdata <= OUT_TDATA_W'({spd32[7:0], spd32[15:8], spd32[23:16],
                                     spd32[31:24], id});
            r_tlast <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= FRAME_LEFT;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_sel   <= is_last ? FRAME_LEFT : r_sel + 2'd1;
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

endmodule

>>> hdl/slmc_checker.sv
// Port-level checker for the slew-limited motor command unit, bound to the top level.
// Tracks frame position and words owed; depends on slmc_pkg.
module slmc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [slmc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tlast
);
    import slmc_pkg::*;

    logic [1:0] r_frame_cnt;
    logic [3:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cnt <= '0;
            r_pending   <= '0;
        end else begin
            if (out_acc) begin
                r_frame_cnt <= (r_frame_cnt == 2'(LANES - 1)) ? '0 : r_frame_cnt + 2'd1;
            end
            r_pending <= r_pending + (in_acc ? 4'(LANES) : 4'd0) - 4'(out_acc);
        end
    end

    // tlast marks exactly every third word
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (r_frame_cnt == 2'(LANES - 1))))
        else $error("tlast out of place");

    // never offer a word that no accepted tick owes
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pending != 4'd0))
        else $error("output word without a pending tick");

    // a tick is complete on tlast: no words owed beyond whole ticks after it
    a_whole_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && m_axis_tlast) |=> ((r_pending == 4'd0) || (r_pending == 4'd3)
            || (r_pending == 4'd6) || (r_pending == 4'd9)))
        else $error("words owed do not form whole ticks");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output word changed");

endmodule

bind slew_limited_motor_command_unit slmc_checker u_slmc_checker (.*);
